// File: rtl/tmp_pkg.sv
// Shared constants and types for the trapezoidal motion profile.
// No dependencies.
`timescale 1ns / 1ps

package tmp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 48;
    localparam int TOTAL_W   = TIME_W + 2;
    localparam int ACC_W     = 80;
    localparam int CNT_W     = 6;
    localparam int MUL_LAST  = 31;
    localparam int DIV_LAST  = 63;
    localparam int SQRT_LAST = 31;

    localparam logic [1:0] REG_DISTANCE = 2'd0;
    localparam logic [1:0] REG_VELOCITY = 2'd1;
    localparam logic [1:0] REG_ACCEL    = 2'd2;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_START = 11'b000_0000_0010,
        ST_VV    = 11'b000_0000_0100,
        ST_DA    = 11'b000_0000_1000,
        ST_SQ    = 11'b000_0001_0000,
        ST_TA    = 11'b000_0010_0000,
        ST_Q     = 11'b000_0100_0000,
        ST_TC    = 11'b000_1000_0000,
        ST_M     = 11'b001_0000_0000,
        ST_RAMP  = 11'b010_0000_0000,
        ST_PTC   = 11'b100_0000_0000
    } setup_state_t;

    typedef enum logic [2:0] {
        PH_UP     = 3'b001,
        PH_CRUISE = 3'b010,
        PH_DOWN   = 3'b100
    } phase_t;

endpackage

// File: rtl/trapezoidal_motion_profile.sv
// Trapezoidal motion profile: setup sequencer and five-stage query pipeline.
// Depends on tmp_pkg.
`timescale 1ns / 1ps

// One result per query, presented on m_valid once the request has passed
// through the query pipeline; a new request may enter every cycle unless the
// output stalls. After the last register write the block drops s_ready while
// a shared serial multiplier, a restoring divider and a digit-serial square
// root derive peak velocity, ramp time, cruise time, both distances and the
// total time, or clear them for a zero-length move. Queries then resume.

module trapezoidal_motion_profile (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_query_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_velocity,
    output logic signed [31:0] m_position,
    output logic [31:0]        m_total_time,
    output logic               m_arrived
);

    localparam int F  = tmp_pkg::FRAC_BITS;
    localparam int TW = tmp_pkg::TIME_W;
    localparam int OW = tmp_pkg::TOTAL_W;
    localparam int AW = tmp_pkg::ACC_W;
    localparam int CW = tmp_pkg::CNT_W;

    // configuration registers
    logic [31:0] md_reg;
    logic [30:0] vl_reg, al_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md_reg <= '0;
            vl_reg <= '0;
            al_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                tmp_pkg::REG_DISTANCE: md_reg <= cfg_data;
                tmp_pkg::REG_VELOCITY: vl_reg <= cfg_data[30:0];
                tmp_pkg::REG_ACCEL:    al_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic        neg;
    logic [31:0] dist_mag;
    assign neg      = md_reg[31];
    assign dist_mag = neg ? (32'd0 - md_reg) : md_reg;

    // setup sequencer
    tmp_pkg::setup_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   ma_reg, ma_next;
    logic [TW-1:0] mb_reg, mb_next;
    logic [AW-1:0] acc_reg, acc_next, acc_step;
    logic [63:0]   dn_reg, dn_next;
    logic [30:0]   dd_reg, dd_next;
    logic [31:0]   dr_reg, dr_next;
    logic [63:0]   dq_reg, dq_next;
    logic [32:0]   dr_sh;
    logic [31:0]   dr_step;
    logic [63:0]   dq_step;
    logic [33:0]   sr_reg, sr_next, sr_sh, sr_trial, sr_step;
    logic [31:0]   sq_reg, sq_next, sq_step;
    logic [61:0]   vv_reg, vv_next;
    logic          tri_reg, tri_next;
    logic [30:0]   peak_reg, peak_next;
    logic [TW-1:0] ta_reg, ta_next, tc_reg, tc_next;
    logic [OW-1:0] total_reg, total_next;
    logic [31:0]   ramp_reg, ramp_next, ptc_reg, ptc_next, q_sub;
    logic          busy;

    assign acc_step = {acc_reg[AW-2:0], 1'b0} + (ma_reg[31] ? {{(AW-TW){1'b0}}, mb_reg} : '0);
    assign dr_sh    = {dr_reg, dn_reg[63]};
    assign dr_step  = (dr_sh >= {2'b0, dd_reg}) ? 32'(dr_sh - {2'b0, dd_reg}) : dr_sh[31:0];
    assign dq_step  = {dq_reg[62:0], (dr_sh >= {2'b0, dd_reg})};
    assign sr_sh    = {sr_reg[31:0], dn_reg[63:62]};
    assign sr_trial = {sq_reg, 2'b01};
    assign sr_step  = (sr_sh >= sr_trial) ? (sr_sh - sr_trial) : sr_sh;
    assign sq_step  = {sq_reg[30:0], (sr_sh >= sr_trial)};
    assign q_sub    = dist_mag - dq_step[31:0];
    assign busy     = (state_reg != tmp_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        ma_next    = {ma_reg[30:0], 1'b0};
        mb_next    = mb_reg;
        acc_next   = acc_step;
        dn_next    = dn_reg;
        dd_next    = dd_reg;
        dr_next    = dr_step;
        dq_next    = dq_step;
        sr_next    = sr_step;
        sq_next    = sq_step;
        vv_next    = vv_reg;
        tri_next   = tri_reg;
        peak_next  = peak_reg;
        ta_next    = ta_reg;
        tc_next    = tc_reg;
        total_next = total_reg;
        ramp_next  = ramp_reg;
        ptc_next   = ptc_reg;
        case (state_reg)
            tmp_pkg::ST_IDLE: begin
                cnt_next = '0;
            end
            tmp_pkg::ST_START: begin
                cnt_next = '0;
                acc_next = '0;
                if (dist_mag == '0 || vl_reg == '0 || al_reg == '0) begin
                    peak_next  = '0;
                    ta_next    = '0;
                    tc_next    = '0;
                    total_next = '0;
                    ramp_next  = '0;
                    ptc_next   = '0;
                    state_next = tmp_pkg::ST_IDLE;
                end else begin
                    ma_next    = {1'b0, vl_reg};
                    mb_next    = TW'(vl_reg);
                    state_next = tmp_pkg::ST_VV;
                end
            end
            tmp_pkg::ST_VV: begin
                if (cnt_reg == CW'(tmp_pkg::MUL_LAST)) begin
                    vv_next    = acc_step[61:0];
                    cnt_next   = '0;
                    acc_next   = '0;
                    ma_next    = dist_mag;
                    mb_next    = TW'(al_reg);
                    state_next = tmp_pkg::ST_DA;
                end
            end
            tmp_pkg::ST_DA: begin
                if (cnt_reg == CW'(tmp_pkg::MUL_LAST)) begin
                    cnt_next = '0;
                    dr_next  = '0;
                    dq_next  = '0;
                    sr_next  = '0;
                    sq_next  = '0;
                    if (vv_reg <= acc_step[61:0]) begin
                        tri_next   = 1'b0;
                        peak_next  = vl_reg;
                        dn_next    = 64'(vl_reg) << F;
                        dd_next    = al_reg;
                        state_next = tmp_pkg::ST_TA;
                    end else begin
                        tri_next   = 1'b1;
                        dn_next    = {2'b0, acc_step[61:0]};
                        state_next = tmp_pkg::ST_SQ;
                    end
                end
            end
            tmp_pkg::ST_SQ: begin
                dn_next = {dn_reg[61:0], 2'b0};
                if (cnt_reg == CW'(tmp_pkg::SQRT_LAST)) begin
                    peak_next  = sq_step[30:0];
                    cnt_next   = '0;
                    dr_next    = '0;
                    dq_next    = '0;
                    dn_next    = 64'(sq_step[30:0]) << F;
                    dd_next    = al_reg;
                    state_next = tmp_pkg::ST_TA;
                end
            end
            tmp_pkg::ST_TA, tmp_pkg::ST_Q, tmp_pkg::ST_TC: begin
                dn_next = {dn_reg[62:0], 1'b0};
                if (cnt_reg == CW'(tmp_pkg::DIV_LAST)) begin
                    cnt_next = '0;
                    dr_next  = '0;
                    dq_next  = '0;
                    acc_next = '0;
                    if (state_reg == tmp_pkg::ST_TA && !tri_reg) begin
                        ta_next    = dq_step[TW-1:0];
                        dn_next    = {2'b0, vv_reg};
                        dd_next    = al_reg;
                        state_next = tmp_pkg::ST_Q;
                    end else if (state_reg == tmp_pkg::ST_Q) begin
                        dn_next    = 64'(q_sub) << F;
                        dd_next    = vl_reg;
                        state_next = tmp_pkg::ST_TC;
                    end else begin
                        if (state_reg == tmp_pkg::ST_TA) begin
                            ta_next = dq_step[TW-1:0];
                            tc_next = '0;
                            mb_next = dq_step[TW-1:0];
                        end else begin
                            tc_next = dq_step[TW-1:0];
                            mb_next = ta_reg;
                        end
                        ma_next    = {1'b0, al_reg};
                        state_next = tmp_pkg::ST_M;
                    end
                end
            end
            tmp_pkg::ST_M: begin
                if (cnt_reg == CW'(tmp_pkg::MUL_LAST)) begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    ma_next    = acc_step[F+31:F];
                    mb_next    = ta_reg;
                    state_next = tmp_pkg::ST_RAMP;
                end
            end
            tmp_pkg::ST_RAMP: begin
                if (cnt_reg == CW'(tmp_pkg::MUL_LAST)) begin
                    ramp_next  = acc_step[F+32:F+1];
                    cnt_next   = '0;
                    acc_next   = '0;
                    ma_next    = {1'b0, peak_reg};
                    mb_next    = tc_reg;
                    state_next = tmp_pkg::ST_PTC;
                end
            end
            tmp_pkg::ST_PTC: begin
                if (cnt_reg == CW'(tmp_pkg::MUL_LAST)) begin
                    ptc_next   = acc_step[F+31:F];
                    total_next = {1'b0, ta_reg, 1'b0} + OW'(tc_reg);
                    state_next = tmp_pkg::ST_IDLE;
                end
            end
            default: state_next = tmp_pkg::ST_IDLE;
        endcase
        if (cfg_we) begin
            state_next = tmp_pkg::ST_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmp_pkg::ST_IDLE;
            peak_reg  <= '0;
            ta_reg    <= '0;
            tc_reg    <= '0;
            total_reg <= '0;
            ramp_reg  <= '0;
            ptc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            peak_reg  <= peak_next;
            ta_reg    <= ta_next;
            tc_reg    <= tc_next;
            total_reg <= total_next;
            ramp_reg  <= ramp_next;
            ptc_reg   <= ptc_next;
        end
        cnt_reg <= cnt_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        dn_reg  <= dn_next;
        dd_reg  <= dd_next;
        dr_reg  <= dr_next;
        dq_reg  <= dq_next;
        sr_reg  <= sr_next;
        sq_reg  <= sq_next;
        vv_reg  <= vv_next;
        tri_reg <= tri_next;
    end

    // query pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1 && !busy;

    // stage 1: phase and time offsets
    tmp_pkg::phase_t ph1_reg, ph1_next, ph2_reg, ph3_reg;
    logic        in1_reg, in1_next, in2_reg, in3_reg, in4_reg;
    logic        full1_reg, full1_next, full2_reg, full3_reg, full4_reg;
    logic        arr1_reg, arr1_next, arr2_reg, arr3_reg, arr4_reg;
    logic [31:0] x1_reg, x1_next, y1_reg, y1_next, x2_reg;
    logic [31:0] dt, td;
    logic [TW:0] tatc;

    assign tatc = {1'b0, ta_reg} + {1'b0, tc_reg};
    assign dt   = s_query_time - ta_reg[31:0];
    assign td   = dt - tc_reg[31:0];

    always_comb begin
        in1_next   = (s_query_time != '0) && (OW'(s_query_time) < total_reg);
        full1_next = (s_query_time != '0) && !in1_next;
        arr1_next  = OW'(s_query_time) >= total_reg;
        if (TW'(s_query_time) < ta_reg) begin
            ph1_next = tmp_pkg::PH_UP;
            x1_next  = s_query_time;
            y1_next  = '0;
        end else if ((TW+1)'(s_query_time) < tatc) begin
            ph1_next = tmp_pkg::PH_CRUISE;
            x1_next  = '0;
            y1_next  = dt;
        end else begin
            ph1_next = tmp_pkg::PH_DOWN;
            x1_next  = td;
            y1_next  = td;
        end
    end

    // stage 2: A*x and peak*y
    logic [62:0] m1_reg, m2_reg;

    // stage 3: decel term squared and peak term shift
    logic [31:0] dec3_reg;
    logic [63:0] m3_reg;
    logic [46:0] p3_reg;

    // stage 4: velocity and position magnitudes
    logic [31:0] vel4_reg, vel4_next;
    logic [49:0] pos4_reg, pos4_next, sum4, sub4;

    always_comb begin
        sum4 = 50'(ramp_reg) + 50'(ptc_reg) + 50'(p3_reg);
        sub4 = 50'(m3_reg >> (F + 1));
        case (ph3_reg)
            tmp_pkg::PH_UP: begin
                vel4_next = dec3_reg;
                pos4_next = sub4;
            end
            tmp_pkg::PH_CRUISE: begin
                vel4_next = {1'b0, peak_reg};
                pos4_next = 50'(ramp_reg) + 50'(p3_reg);
            end
            default: begin
                vel4_next = (dec3_reg >= {1'b0, peak_reg}) ? '0 : ({1'b0, peak_reg} - dec3_reg);
                pos4_next = (sub4 > sum4) ? '0 : (sum4 - sub4);
            end
        endcase
    end

    // stage 5: clamp, sign and select
    logic [31:0] vel5, pos5;
    logic [31:0] vel_reg, vel_next, pos_reg, pos_next, tot_reg, tot_next;
    logic        arr_reg;

    always_comb begin
        vel5 = (vel4_reg > {1'b0, peak_reg}) ? {1'b0, peak_reg} : vel4_reg;
        pos5 = (pos4_reg > 50'(dist_mag)) ? dist_mag : pos4_reg[31:0];
        if (!in4_reg) begin
            vel5 = '0;
            pos5 = '0;
        end
        vel_next = neg ? (32'd0 - vel5) : vel5;
        pos_next = full4_reg ? md_reg : (neg ? (32'd0 - pos5) : pos5);
        tot_next = (total_reg > OW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : total_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid && s_ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
        if (en1) begin
            ph1_reg   <= ph1_next;
            in1_reg   <= in1_next;
            full1_reg <= full1_next;
            arr1_reg  <= arr1_next;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
        end
        if (en2) begin
            ph2_reg   <= ph1_reg;
            in2_reg   <= in1_reg;
            full2_reg <= full1_reg;
            arr2_reg  <= arr1_reg;
            x2_reg    <= x1_reg;
            m1_reg    <= 63'(al_reg) * 63'(x1_reg);
            m2_reg    <= 63'(peak_reg) * 63'(y1_reg);
        end
        if (en3) begin
            ph3_reg   <= ph2_reg;
            in3_reg   <= in2_reg;
            full3_reg <= full2_reg;
            arr3_reg  <= arr2_reg;
            dec3_reg  <= m1_reg[F+31:F];
            m3_reg    <= 64'(m1_reg[F+31:F]) * 64'(x2_reg);
            p3_reg    <= m2_reg[62:F];
        end
        if (en4) begin
            in4_reg   <= in3_reg;
            full4_reg <= full3_reg;
            arr4_reg  <= arr3_reg;
            vel4_reg  <= vel4_next;
            pos4_reg  <= pos4_next;
        end
        if (en5) begin
            vel_reg   <= vel_next;
            pos_reg   <= pos_next;
            tot_reg   <= tot_next;
            arr_reg   <= arr4_reg;
        end
    end

    assign m_valid      = v5_reg;
    assign m_velocity   = vel_reg;
    assign m_position   = pos_reg;
    assign m_total_time = tot_reg;
    assign m_arrived    = arr_reg;

endmodule

// File: rtl/tmp_checker.sv
// Port-level checks for the trapezoidal motion profile, bound to the top level.
// Depends on trapezoidal_motion_profile.
`timescale 1ns / 1ps

module tmp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_velocity,
    input logic [31:0] m_total_time,
    input logic        m_arrived
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_velocity))
        else $error("stalled result changed");

    a_arrived_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arrived |-> m_velocity == 32'd0)
        else $error("moving after arrival");

    a_zero_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_total_time == 32'd0 |-> m_arrived)
        else $error("zero-length move not arrived");

endmodule

bind trapezoidal_motion_profile tmp_checker u_tmp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_velocity   (m_velocity),
    .m_total_time (m_total_time),
    .m_arrived    (m_arrived)
);
